### rtl/core/assert_macros.svh
// assertion helpers used by the rtl datapath
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define PTB_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("ptb assertion failed");

// next-cycle implication
`define PTB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("ptb assertion failed");

`endif

### rtl/core/ptb_pkg.sv
`default_nettype none
package ptb_pkg;

	// request codes
	localparam logic [2:0] REQ_SCHEDULE = 3'd0;
	localparam logic [2:0] REQ_REMOVE   = 3'd1;
	localparam logic [2:0] REQ_TICK     = 3'd2;
	localparam logic [2:0] REQ_STOP     = 3'd3;
	localparam logic [2:0] REQ_START    = 3'd4;

	// result status codes
	localparam logic [3:0] ST_SCHEDULED = 4'd0;
	localparam logic [3:0] ST_REJECTED  = 4'd1;
	localparam logic [3:0] ST_REMOVED   = 4'd2;
	localparam logic [3:0] ST_NOT_FOUND = 4'd3;
	localparam logic [3:0] ST_FIRED     = 4'd4;
	localparam logic [3:0] ST_IDLE_TICK = 4'd5;
	localparam logic [3:0] ST_STARTED   = 4'd6;
	localparam logic [3:0] ST_STOPPED   = 4'd7;
	localparam logic [3:0] ST_UNCHANGED = 4'd8;

	// most fired ids released by one tick
	localparam int MAX_RESULTS = 16;

	localparam int SLOT_W = 112;

	localparam logic [2:0] ADDR_BATCH = 3'd0;
	localparam logic [31:0] BATCH_RESET = 32'd10000;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DISPATCH,
		S_SCH,
		S_RM_RD,
		S_RM_CMP,
		S_TK_RD,
		S_TK_CMP,
		S_TK_COMMIT,
		S_TK_REL,
		S_REL_RD,
		S_REL_EMIT,
		S_EMIT
	} state_t;

	typedef struct packed {
		logic       ld_req;
		logic       idx_clr;
		logic       idx_inc;
		logic       set_st;
		logic [3:0] st;
		logic       sch_write;
		logic       rm_clear;
		logic       stop_do;
		logic       start_do;
		logic       tick_init;
		logic       cand_take;
		logic       commit;
		logic       rel_start;
		logic       pop;
		logic       emit;
	} ptb_cmd_t;

	typedef struct packed {
		logic [2:0] req;
		logic       period_zero;
		logic       running;
		logic       idx_last;
		logic       free_here;
		logic       match;
		logic       cand_better;
		logic       best_found;
		logic       release_ok;
		logic       pend_empty;
		logic       rel_last;
		logic       out_free;
	} ptb_sts_t;

endpackage
`default_nettype wire

### rtl/core/periodic_task_timer_bank.sv
// channel   direction  handshake                 payload
// request   in         in_valid / in_stall       req_type tmr_period target_id now_us
// result    out        out_valid / out_stall     status timer_id last_of_run queue_dropped
// config    in         apb psel/penable/pwrite   paddr pwdata prdata pready
//
// one request transaction at a time; a schedule scans the slots for a free one, a remove
// scans for the target id, and a tick rescans the slot table after each due timer it
// commits, then releases the pending ids one at a time; the remove and tick scans read
// each slot from the slot ram (registered read) before comparing it
// results leave through an output register; a stalled result holds the controller
// arst_n clears control state, the slot valid bits and the pending queue count
`default_nettype none
module periodic_task_timer_bank #(
	parameter int NUM_TIMERS    = 16,
	parameter int PENDING_DEPTH = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// request channel
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [2:0]  req_type,
	input  wire logic [31:0] tmr_period,
	input  wire logic [31:0] target_id,
	input  wire logic [47:0] now_us,
	// result channel
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [3:0]       status,
	output logic [31:0]      timer_id,
	output logic             last_of_run,
	output logic             queue_dropped,
	// configuration port
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);

	ptb_pkg::ptb_cmd_t cmd;
	ptb_pkg::ptb_sts_t sts;
	logic [31:0] batch_q;

	// batch interval register, written in the apb access phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			batch_q <= ptb_pkg::BATCH_RESET;
		end else if (psel && penable && pwrite && paddr == ptb_pkg::ADDR_BATCH) begin
			batch_q <= pwdata;
		end
	end

	assign pready = 1'b1;
	assign prdata = (paddr == ptb_pkg::ADDR_BATCH) ? batch_q : '0;

	// sequencer: decodes the request and steps the scans
	ptb_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	// slot table, pending ring, timers and result register
	ptb_dp #(
		.NUM_TIMERS    (NUM_TIMERS),
		.PENDING_DEPTH (PENDING_DEPTH)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.rel_gap        (batch_q),
		.req_type       (req_type),
		.tmr_period     (tmr_period),
		.target_id      (target_id),
		.now_us         (now_us),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.status         (status),
		.timer_id       (timer_id),
		.last_of_run    (last_of_run),
		.queue_dropped  (queue_dropped)
	);

endmodule
`default_nettype wire

### rtl/core/ptb_ram.sv
`default_nettype none
module ptb_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  wire logic                                       clk,
	input  wire logic                                       wr_en,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]                           wr_data,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic      [WIDTH-1:0]                           rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end

endmodule
`default_nettype wire

### rtl/core/ptb_ctrl.sv
`default_nettype none
module ptb_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_stall,
	input  wire ptb_pkg::ptb_sts_t sts,
	output ptb_pkg::ptb_cmd_t     cmd
);

	ptb_pkg::state_t state_q, state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ptb_pkg::S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	assign in_stall = (state_q != ptb_pkg::S_IDLE);

	// next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ptb_pkg::S_IDLE: begin
				if (in_valid) state_nxt = ptb_pkg::S_DISPATCH;
			end
			ptb_pkg::S_DISPATCH: begin
				unique case (sts.req)
					ptb_pkg::REQ_SCHEDULE:
						state_nxt = sts.period_zero ? ptb_pkg::S_EMIT : ptb_pkg::S_SCH;
					ptb_pkg::REQ_REMOVE: state_nxt = ptb_pkg::S_RM_RD;
					ptb_pkg::REQ_TICK:
						state_nxt = sts.running ? ptb_pkg::S_TK_RD : ptb_pkg::S_EMIT;
					default: state_nxt = ptb_pkg::S_EMIT;
				endcase
			end
			ptb_pkg::S_SCH: begin
				if (sts.free_here || sts.idx_last) state_nxt = ptb_pkg::S_EMIT;
			end
			ptb_pkg::S_RM_RD: state_nxt = ptb_pkg::S_RM_CMP;
			ptb_pkg::S_RM_CMP: begin
				if (sts.match || sts.idx_last) state_nxt = ptb_pkg::S_EMIT;
				else state_nxt = ptb_pkg::S_RM_RD;
			end
			ptb_pkg::S_TK_RD: state_nxt = ptb_pkg::S_TK_CMP;
			ptb_pkg::S_TK_CMP: begin
				if (!sts.idx_last) state_nxt = ptb_pkg::S_TK_RD;
				else if (sts.best_found || sts.cand_better) state_nxt = ptb_pkg::S_TK_COMMIT;
				else state_nxt = ptb_pkg::S_TK_REL;
			end
			ptb_pkg::S_TK_COMMIT: state_nxt = ptb_pkg::S_TK_RD;
			ptb_pkg::S_TK_REL: begin
				if (sts.release_ok && !sts.pend_empty) state_nxt = ptb_pkg::S_REL_RD;
				else state_nxt = ptb_pkg::S_EMIT;
			end
			ptb_pkg::S_REL_RD: state_nxt = ptb_pkg::S_REL_EMIT;
			ptb_pkg::S_REL_EMIT: begin
				if (sts.out_free) begin
					state_nxt = sts.rel_last ? ptb_pkg::S_IDLE : ptb_pkg::S_REL_RD;
				end
			end
			ptb_pkg::S_EMIT: begin
				if (sts.out_free) state_nxt = ptb_pkg::S_IDLE;
			end
			default: state_nxt = ptb_pkg::S_IDLE;
		endcase
	end

	// commands
	always_comb begin
		cmd = '0;
		unique case (state_q)
			ptb_pkg::S_IDLE: begin
				cmd.ld_req = in_valid;
			end
			ptb_pkg::S_DISPATCH: begin
				cmd.idx_clr = 1'b1;
				cmd.set_st  = 1'b1;
				cmd.st      = ptb_pkg::ST_UNCHANGED;
				unique case (sts.req)
					ptb_pkg::REQ_SCHEDULE: cmd.st = ptb_pkg::ST_REJECTED;
					ptb_pkg::REQ_REMOVE:   cmd.st = ptb_pkg::ST_NOT_FOUND;
					ptb_pkg::REQ_TICK:     cmd.tick_init = sts.running;
					ptb_pkg::REQ_STOP: begin
						if (sts.running) begin
							cmd.stop_do = 1'b1;
							cmd.st      = ptb_pkg::ST_STOPPED;
						end
					end
					ptb_pkg::REQ_START: begin
						if (!sts.running) begin
							cmd.start_do = 1'b1;
							cmd.st       = ptb_pkg::ST_STARTED;
						end
					end
					default: cmd.st = ptb_pkg::ST_UNCHANGED;
				endcase
			end
			ptb_pkg::S_SCH: begin
				if (sts.free_here) begin
					cmd.sch_write = 1'b1;
					cmd.set_st    = 1'b1;
					cmd.st        = ptb_pkg::ST_SCHEDULED;
				end else if (!sts.idx_last) begin
					cmd.idx_inc = 1'b1;
				end
			end
			ptb_pkg::S_RM_RD: begin
				cmd = '0;
			end
			ptb_pkg::S_RM_CMP: begin
				if (sts.match) begin
					cmd.rm_clear = 1'b1;
					cmd.set_st   = 1'b1;
					cmd.st       = ptb_pkg::ST_REMOVED;
				end else if (!sts.idx_last) begin
					cmd.idx_inc = 1'b1;
				end
			end
			ptb_pkg::S_TK_RD: begin
				cmd = '0;
			end
			ptb_pkg::S_TK_CMP: begin
				cmd.cand_take = sts.cand_better;
				cmd.idx_inc   = !sts.idx_last;
			end
			ptb_pkg::S_TK_COMMIT: begin
				cmd.commit  = 1'b1;
				cmd.idx_clr = 1'b1;
			end
			ptb_pkg::S_TK_REL: begin
				cmd.rel_start = sts.release_ok;
				cmd.set_st    = 1'b1;
				cmd.st        = (sts.release_ok && !sts.pend_empty) ?
					ptb_pkg::ST_FIRED : ptb_pkg::ST_IDLE_TICK;
			end
			ptb_pkg::S_REL_RD: begin
				cmd = '0;
			end
			ptb_pkg::S_REL_EMIT: begin
				cmd.emit = sts.out_free;
				cmd.pop  = sts.out_free;
			end
			ptb_pkg::S_EMIT: begin
				cmd.emit = sts.out_free;
			end
			default: cmd = '0;
		endcase
	end

endmodule
`default_nettype wire

### rtl/core/ptb_dp.sv
`default_nettype none
`include "assert_macros.svh"
module ptb_dp #(
	parameter int NUM_TIMERS    = 16,
	parameter int PENDING_DEPTH = 16
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire ptb_pkg::ptb_cmd_t cmd,
	output ptb_pkg::ptb_sts_t      sts,
	input  wire logic [31:0]       rel_gap,
	input  wire logic [2:0]        req_type,
	input  wire logic [31:0]       tmr_period,
	input  wire logic [31:0]       target_id,
	input  wire logic [47:0]       now_us,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output logic [3:0]             status,
	output logic [31:0]            timer_id,
	output logic                   last_of_run,
	output logic                   queue_dropped
);

	localparam int IW = $clog2(NUM_TIMERS);
	localparam int PW = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;
	localparam int CW = $clog2(PENDING_DEPTH + 1);
	localparam int SW = CW + 1;

	logic [2:0]            req_q;
	logic [31:0]           period_q;
	logic [31:0]           target_q;
	logic [47:0]           now_q;
	logic [IW-1:0]         idx_q;
	logic [NUM_TIMERS-1:0] valid_q;
	logic [NUM_TIMERS-1:0] seen_q;
	logic [31:0]           id_cnt_q;
	logic                  running_q;
	logic [47:0]           last_rel_q;
	logic                  best_found_q;
	logic [IW-1:0]         best_idx_q;
	logic [31:0]           best_id_q;
	logic [31:0]           best_per_q;
	logic                  drop_q;
	logic [PW-1:0]         head_q;
	logic [CW-1:0]         count_q;
	logic [3:0]            k_q;
	logic [3:0]            st_q;

	logic [ptb_pkg::SLOT_W-1:0] slot_wdata, slot_rd;
	logic [31:0] rd_id, rd_per, pend_rd, add_per, wr_id;
	logic [47:0] rd_due, due_new;
	logic [48:0] due_sum;
	logic [SW-1:0] tail_sum, tail;
	logic push_ok, rel_last, release_ok;
	logic [47:0] elapsed;

	assign rd_id  = slot_rd[111:80];
	assign rd_per = slot_rd[79:48];
	assign rd_due = slot_rd[47:0];

	// rearm / first due time, saturating at the top of the 48-bit range
	assign add_per = cmd.sch_write ? period_q : best_per_q;
	assign wr_id   = cmd.sch_write ? id_cnt_q : best_id_q;
	assign due_sum = {1'b0, now_q} + {17'd0, add_per};
	assign due_new = due_sum[48] ? {48{1'b1}} : due_sum[47:0];
	assign slot_wdata = {wr_id, add_per, due_new};

	ptb_ram #(.WIDTH(ptb_pkg::SLOT_W), .DEPTH(NUM_TIMERS)) u_slot_ram (
		.clk     (clk),
		.wr_en   (cmd.sch_write | cmd.commit),
		.wr_addr (cmd.sch_write ? idx_q : best_idx_q),
		.wr_data (slot_wdata),
		.rd_addr (idx_q),
		.rd_data (slot_rd)
	);

	// pending queue as a ring
	assign push_ok  = count_q < CW'(PENDING_DEPTH);
	assign tail_sum = SW'(head_q) + SW'(count_q);
	assign tail     = (tail_sum >= SW'(PENDING_DEPTH)) ? tail_sum - SW'(PENDING_DEPTH) : tail_sum;

	ptb_ram #(.WIDTH(32), .DEPTH(PENDING_DEPTH)) u_pend_ram (
		.clk     (clk),
		.wr_en   (cmd.commit & push_ok),
		.wr_addr (tail[PW-1:0]),
		.wr_data (best_id_q),
		.rd_addr (head_q),
		.rd_data (pend_rd)
	);

	// time going backwards counts as no time passed
	assign elapsed    = (now_q >= last_rel_q) ? now_q - last_rel_q : '0;
	assign release_ok = elapsed >= {16'd0, rel_gap};
	assign rel_last   = (count_q == CW'(1)) || (k_q == 4'(ptb_pkg::MAX_RESULTS - 1));

	always_comb begin
		sts.req         = req_q;
		sts.period_zero = (period_q == '0);
		sts.running     = running_q;
		sts.idx_last    = (idx_q == IW'(NUM_TIMERS - 1));
		sts.free_here   = !valid_q[idx_q];
		sts.match       = valid_q[idx_q] && (rd_id == target_q);
		sts.cand_better = valid_q[idx_q] && !seen_q[idx_q] && (now_q >= rd_due) &&
			(!best_found_q || (rd_id < best_id_q));
		sts.best_found  = best_found_q;
		sts.release_ok  = release_ok;
		sts.pend_empty  = (count_q == '0);
		sts.rel_last    = rel_last;
		sts.out_free    = !out_valid || !out_stall;
	end

	// request fields
	always_ff @(posedge clk) begin
		if (cmd.ld_req) begin
			req_q    <= req_type;
			period_q <= tmr_period;
			target_q <= target_id;
			now_q    <= now_us;
		end
		if (cmd.cand_take) begin
			best_idx_q <= idx_q;
			best_id_q  <= rd_id;
			best_per_q <= rd_per;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q        <= '0;
			valid_q      <= '0;
			seen_q       <= '0;
			id_cnt_q     <= 32'd1;
			running_q    <= 1'b0;
			last_rel_q   <= '0;
			best_found_q <= 1'b0;
			drop_q       <= 1'b0;
			head_q       <= '0;
			count_q      <= '0;
			k_q          <= '0;
			st_q         <= ptb_pkg::ST_UNCHANGED;
		end else begin
			if (cmd.idx_clr) idx_q <= '0;
			else if (cmd.idx_inc) idx_q <= idx_q + IW'(1);
			if (cmd.set_st) st_q <= cmd.st;
			if (cmd.sch_write) valid_q[idx_q] <= 1'b1;
			if (cmd.rm_clear) valid_q[idx_q] <= 1'b0;
			if (cmd.stop_do) begin
				valid_q   <= '0;
				running_q <= 1'b0;
			end
			if (cmd.start_do) begin
				running_q  <= 1'b1;
				last_rel_q <= now_q;
			end
			if (cmd.tick_init) begin
				seen_q       <= '0;
				drop_q       <= 1'b0;
				best_found_q <= 1'b0;
			end
			if (cmd.cand_take) best_found_q <= 1'b1;
			if (cmd.commit) begin
				seen_q[best_idx_q] <= 1'b1;
				best_found_q       <= 1'b0;
				if (push_ok) count_q <= count_q + CW'(1);
				else drop_q <= 1'b1;
			end
			if (cmd.rel_start) begin
				last_rel_q <= now_q;
				k_q        <= '0;
			end
			if (cmd.pop) begin
				head_q  <= (head_q == PW'(PENDING_DEPTH - 1)) ? '0 : head_q + PW'(1);
				count_q <= count_q - CW'(1);
				k_q     <= k_q + 4'd1;
			end
			// id counter skips zero on wrap
			if (cmd.emit && st_q == ptb_pkg::ST_SCHEDULED) begin
				id_cnt_q <= (id_cnt_q == '1) ? 32'd1 : id_cnt_q + 32'd1;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (cmd.emit) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			status <= st_q;
			case (st_q)
				ptb_pkg::ST_SCHEDULED: begin
					timer_id      <= id_cnt_q;
					last_of_run   <= 1'b1;
					queue_dropped <= 1'b0;
				end
				ptb_pkg::ST_FIRED: begin
					timer_id      <= pend_rd;
					last_of_run   <= rel_last;
					queue_dropped <= drop_q;
				end
				ptb_pkg::ST_IDLE_TICK: begin
					timer_id      <= '0;
					last_of_run   <= 1'b1;
					queue_dropped <= drop_q;
				end
				default: begin
					timer_id      <= '0;
					last_of_run   <= 1'b1;
					queue_dropped <= 1'b0;
				end
			endcase
		end
	end

	`PTB_ASSERT_IMPL(a_count_bound, clk, arst_n, 1'b1, count_q <= CW'(PENDING_DEPTH))
	`PTB_ASSERT_IMPL(a_pop_nonempty, clk, arst_n, cmd.pop, count_q != '0)
	`PTB_ASSERT_NEXT(a_push_grows, clk, arst_n, cmd.commit && push_ok, count_q == $past(count_q) + CW'(1))

endmodule
`default_nettype wire

### test/periodic_task_timer_bank_checker.sv
`timescale 1ns / 100ps
`default_nettype none
module periodic_task_timer_bank_checker (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	input  wire logic        in_stall,
	input  wire logic [2:0]  req_type,
	input  wire logic [31:0] tmr_period,
	input  wire logic [31:0] target_id,
	input  wire logic [47:0] now_us,
	input  wire logic        out_valid,
	input  wire logic        out_stall,
	input  wire logic [3:0]  status,
	input  wire logic [31:0] timer_id,
	input  wire logic        last_of_run,
	input  wire logic        queue_dropped,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic        pready,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output int               fail_count,
	output int               awaiting
);
	localparam int SLOTS = 16;
	localparam int DEPTH = 16;
	localparam logic [47:0] TIME_MAX = 48'hFFFF_FFFF_FFFF;

	typedef struct packed {
		logic [3:0]  st;
		logic [31:0] id;
		logic        last;
		logic        drop;
	} timer_result_t;

	timer_result_t results_q[$];

	logic [31:0] interval;
	logic        live[SLOTS];
	logic [31:0] live_id[SLOTS];
	logic [31:0] live_period[SLOTS];
	logic [47:0] live_due[SLOTS];
	logic [31:0] next_id;
	logic [31:0] fired_q[$];
	logic [47:0] released_at;
	logic        running;

	function automatic logic [47:0] sat_add(logic [47:0] a, logic [31:0] b);
		logic [48:0] s;
		s = {1'b0, a} + {17'd0, b};
		return s > {1'b0, TIME_MAX} ? TIME_MAX : s[47:0];
	endfunction

	function automatic void push(logic [3:0] st, logic [31:0] id, logic last, logic drop);
		timer_result_t r;
		r.st = st;
		r.id = id;
		r.last = last;
		r.drop = drop;
		results_q.insert(results_q.size(), r);
	endfunction

	function automatic void clear_model();
		for (int i = 0; i < SLOTS; i++) live[i] = 1'b0;
		interval = ptb_pkg::BATCH_RESET;
		next_id = 32'd1;
		fired_q.delete();
		released_at = '0;
		running = 1'b0;
		results_q.delete();
	endfunction

	// scan due timers in id order, then release the pending ids once the interval is up
	function automatic void run_tick(logic [47:0] now);
		logic seen[SLOTS];
		logic drop;
		int best;
		int n;
		logic [47:0] elapsed;
		drop = 1'b0;
		for (int i = 0; i < SLOTS; i++) seen[i] = 1'b0;
		forever begin
			best = -1;
			for (int i = 0; i < SLOTS; i++)
				if (live[i] && !seen[i] && now >= live_due[i])
					if (best < 0 || live_id[i] < live_id[best]) best = i;
			if (best < 0) break;
			seen[best] = 1'b1;
			if (fired_q.size() < DEPTH) fired_q.insert(fired_q.size(), live_id[best]);
			else drop = 1'b1;
			live_due[best] = sat_add(now, live_period[best]);
		end
		elapsed = now >= released_at ? now - released_at : '0;
		n = 0;
		if (elapsed >= {16'd0, interval}) begin
			n = fired_q.size() < ptb_pkg::MAX_RESULTS ? fired_q.size() : ptb_pkg::MAX_RESULTS;
			for (int k = 0; k < n; k++)
				push(ptb_pkg::ST_FIRED, fired_q.pop_front(), k == n - 1, drop);
			released_at = now;
		end
		if (n == 0) push(ptb_pkg::ST_IDLE_TICK, '0, 1'b1, drop);
	endfunction

	function automatic void apply_request(logic [2:0] rt, logic [31:0] period,
		logic [31:0] target, logic [47:0] now);
		int slot;
		slot = -1;
		case (rt)
			ptb_pkg::REQ_SCHEDULE: begin
				for (int i = SLOTS - 1; i >= 0; i--) if (!live[i]) slot = i;
				if (period == 0 || slot < 0) begin
					push(ptb_pkg::ST_REJECTED, '0, 1'b1, 1'b0);
				end else begin
					live[slot] = 1'b1;
					live_id[slot] = next_id;
					live_period[slot] = period;
					live_due[slot] = sat_add(now, period);
					push(ptb_pkg::ST_SCHEDULED, next_id, 1'b1, 1'b0);
					next_id = next_id + 1;
					if (next_id == 0) next_id = 32'd1;
				end
			end
			ptb_pkg::REQ_REMOVE: begin
				for (int i = SLOTS - 1; i >= 0; i--) if (live[i] && live_id[i] == target) slot = i;
				if (slot >= 0) begin
					live[slot] = 1'b0;
					push(ptb_pkg::ST_REMOVED, '0, 1'b1, 1'b0);
				end else begin
					push(ptb_pkg::ST_NOT_FOUND, '0, 1'b1, 1'b0);
				end
			end
			ptb_pkg::REQ_TICK: begin
				if (running) run_tick(now);
				else push(ptb_pkg::ST_UNCHANGED, '0, 1'b1, 1'b0);
			end
			ptb_pkg::REQ_STOP: begin
				if (running) begin
					running = 1'b0;
					for (int i = 0; i < SLOTS; i++) live[i] = 1'b0;
					push(ptb_pkg::ST_STOPPED, '0, 1'b1, 1'b0);
				end else begin
					push(ptb_pkg::ST_UNCHANGED, '0, 1'b1, 1'b0);
				end
			end
			ptb_pkg::REQ_START: begin
				if (!running) begin
					running = 1'b1;
					released_at = now;
					push(ptb_pkg::ST_STARTED, '0, 1'b1, 1'b0);
				end else begin
					push(ptb_pkg::ST_UNCHANGED, '0, 1'b1, 1'b0);
				end
			end
			default: push(ptb_pkg::ST_UNCHANGED, '0, 1'b1, 1'b0);
		endcase
	endfunction

	always @(posedge clk or negedge arst_n) begin
		timer_result_t exp_r;
		if (!arst_n) begin
			clear_model();
			fail_count <= 0;
			awaiting <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (results_q.size() == 0) begin
					$error("unexpected result: status %0d timer_id %0d", status, timer_id);
					fail_count <= fail_count + 1;
				end else begin
					exp_r = results_q.pop_front();
					if (status !== exp_r.st)
						$error("status: expected %0d actual %0d", exp_r.st, status);
					if (timer_id !== exp_r.id)
						$error("timer_id: expected %0d actual %0d", exp_r.id, timer_id);
					if (last_of_run !== exp_r.last)
						$error("last_of_run: expected %0d actual %0d", exp_r.last, last_of_run);
					if (queue_dropped !== exp_r.drop)
						$error("queue_dropped: expected %0d actual %0d", exp_r.drop, queue_dropped);
					if (status !== exp_r.st || timer_id !== exp_r.id
						|| last_of_run !== exp_r.last || queue_dropped !== exp_r.drop)
						fail_count <= fail_count + 1;
				end
			end
			if (in_valid && !in_stall) apply_request(req_type, tmr_period, target_id, now_us);
			if (psel && penable && pwrite && pready && paddr == ptb_pkg::ADDR_BATCH)
				interval = pwdata;
			awaiting <= results_q.size();
		end
	end
endmodule
`default_nettype wire

### test/periodic_task_timer_bank_tb.sv
`timescale 1ns / 100ps
`default_nettype none
module periodic_task_timer_bank_tb;

	localparam int CYCLE_LIMIT = 3000000;
	localparam int LONG_HOLD = 400;
	localparam logic [47:0] TIME_MAX = 48'hFFFF_FFFF_FFFF;
	// request codes with no meaning
	localparam logic [2:0] REQ_SPARE_5 = 3'd5;
	localparam logic [2:0] REQ_SPARE_6 = 3'd6;
	localparam logic [2:0] REQ_SPARE_7 = 3'd7;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [2:0]  req_type = ptb_pkg::REQ_TICK;
	logic [31:0] tmr_period = '0;
	logic [31:0] target_id = '0;
	logic [47:0] now_us = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [3:0]  status;
	logic [31:0] timer_id;
	logic        last_of_run;
	logic        queue_dropped;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	int fail_count;
	int awaiting;
	int cycles = 0;
	int sent = 0;
	bit quiet = 1'b0;      // no idling on either side
	bit long_hold = 1'b0;  // asks the result side for one long stall
	logic [47:0] clock_us = '0;
	logic [31:0] guess_id = 32'd1;

	always #5 clk = ~clk;

	periodic_task_timer_bank uut (.*);

	periodic_task_timer_bank_checker checker_i (.*);

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("periodic_task_timer_bank_tb: errors");
			$finish;
		end
	end

	// result side: short random stall bursts, one long hold on request
	initial begin
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (long_hold) begin
				long_hold = 1'b0;
				out_stall <= 1'b1;
				repeat (LONG_HOLD) @(posedge clk);
				out_stall <= 1'b0;
			end else if (!quiet && $urandom_range(0, 5) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 3)) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	// one request transaction, with an optional random gap in front
	task automatic send(logic [2:0] rt, logic [31:0] per, logic [31:0] tgt, logic [47:0] now);
		if (!quiet && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		in_valid <= 1'b1;
		req_type <= rt;
		tmr_period <= per;
		target_id <= tgt;
		now_us <= now;
		do @(posedge clk); while (in_stall);
		sent++;
	endtask

	task automatic go_idle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (awaiting != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	// apb write: setup cycle then access cycle
	task automatic write_interval(logic [31:0] value);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= ptb_pkg::ADDR_BATCH;
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic [31:0] pick_period();
		case ($urandom_range(0, 9))
			0: return $urandom;
			1: return 32'd0;
			default: return $urandom_range(1, 300);
		endcase
	endfunction

	// well-formed run: start, fill the table, tick through time, remove some, mostly stop
	task automatic timer_session(int budget);
		int nsched;
		int nticks;
		logic [31:0] per;
		nsched = $urandom_range(1, 18);
		nticks = $urandom_range(3, 14);
		send(ptb_pkg::REQ_START, $urandom, $urandom, clock_us);
		for (int i = 0; i < nsched && sent < budget; i++) begin
			per = pick_period();
			send(ptb_pkg::REQ_SCHEDULE, per, $urandom, clock_us);
			if (per != 0) guess_id++;
		end
		for (int i = 0; i < nticks && sent < budget; i++) begin
			if ($urandom_range(0, 9) == 0) clock_us = clock_us - $urandom_range(0, 50);
			else clock_us = clock_us + $urandom_range(0, 400);
			if ($urandom_range(0, 30) == 0) clock_us = clock_us + 48'd5000000000;
			send(ptb_pkg::REQ_TICK, $urandom, $urandom, clock_us);
			if ($urandom_range(0, 3) == 0)
				send(ptb_pkg::REQ_REMOVE, $urandom, guess_id - $urandom_range(1, 20), clock_us);
		end
		if ($urandom_range(0, 3) != 0) send(ptb_pkg::REQ_STOP, $urandom, $urandom, clock_us);
	endtask

	// noise: any code, any field value
	task automatic noise_item();
		logic [47:0] t;
		t = 48'({$urandom, $urandom});
		send(3'($urandom_range(0, 7)), $urandom, $urandom, t);
	endtask

	task automatic random_phase(int budget);
		while (sent < budget) begin
			if ($urandom_range(0, 4) == 0) noise_item();
			else timer_session(budget);
		end
		send(ptb_pkg::REQ_STOP, '0, '0, clock_us);
		go_idle();
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part under the reset interval
		send(ptb_pkg::REQ_TICK, '0, '0, 48'd100);
		send(ptb_pkg::REQ_STOP, '0, '0, '0);
		send(ptb_pkg::REQ_START, '0, '0, '0);
		send(ptb_pkg::REQ_START, '0, '0, 48'd1);
		send(ptb_pkg::REQ_SCHEDULE, '0, '0, '0);
		send(ptb_pkg::REQ_SCHEDULE, 32'd1, '0, '0);
		send(ptb_pkg::REQ_SCHEDULE, 32'd5000, '0, '0);
		send(ptb_pkg::REQ_SCHEDULE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, TIME_MAX - 48'd10);
		send(ptb_pkg::REQ_REMOVE, '0, 32'hFFFF_FFFF, '0);
		send(ptb_pkg::REQ_REMOVE, '0, 32'd0, '0);
		send(ptb_pkg::REQ_TICK, '0, '0, 48'd10000);
		send(ptb_pkg::REQ_TICK, '0, '0, 48'd5);
		send(ptb_pkg::REQ_REMOVE, '0, 32'd2, '0);
		send(REQ_SPARE_5, 32'hFFFF_FFFF, 32'hFFFF_FFFF, TIME_MAX);
		send(REQ_SPARE_6, '0, '0, '0);
		send(REQ_SPARE_7, '0, '0, '0);
		send(ptb_pkg::REQ_TICK, '0, '0, TIME_MAX);
		send(ptb_pkg::REQ_TICK, '0, '0, TIME_MAX);
		send(ptb_pkg::REQ_STOP, '0, '0, '0);
		send(ptb_pkg::REQ_STOP, '0, '0, '0);
		guess_id = 32'd4;
		go_idle();

		// release on every tick
		write_interval(32'd0);
		random_phase(80);

		// short interval, one long stall of the result side so the block backs up
		write_interval(32'd100);
		long_hold = 1'b1;
		random_phase(140);

		// releases almost never come, so the pending queue overflows
		write_interval(32'hFFFF_FFFF);
		random_phase(200);

		// last stretch without idling
		write_interval(32'd37);
		quiet = 1'b1;
		random_phase(255);

		in_valid <= 1'b0;
		repeat (600) @(posedge clk);
		if (fail_count == 0 && awaiting == 0) begin
			$display("periodic_task_timer_bank_tb: clean");
		end else begin
			$display("periodic_task_timer_bank_tb: errors");
		end
		$finish;
	end
endmodule
`default_nettype wire
